FILE: hdl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared constants and types for the 5x5 weighted median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_SIZE    = 5;

    localparam int PIX_BITS    = 8;
    localparam int CFG_BITS    = 11;
    localparam int POS_BITS    = 10;
    localparam int LINES       = 4;
    localparam int WIN_DIM     = 5;
    localparam int WIN_SIZE    = WIN_DIM * WIN_DIM;
    localparam int SUM_BITS    = 6;
    localparam int HALF_WEIGHT = 17;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

    // register indexes of the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // inner 3x3 of the window weighs 2, the outer ring 1
    localparam logic [WIN_SIZE-1:0] INNER_MASK = 25'b000000_111_00_111_00_111_000000;
    localparam logic [WIN_SIZE-1:0] OUTER_MASK = ~INNER_MASK;

    typedef logic [PIX_BITS-1:0]              pix_t;
    typedef logic [COL_BITS-1:0]              col_t;
    typedef logic [ROW_BITS-1:0]              row_t;
    typedef logic [COL_BITS:0]                wsize_t;
    typedef logic [ROW_BITS:0]                hsize_t;
    typedef logic [POS_BITS-1:0]              pos_field_t;
    typedef logic [LINES-1:0][PIX_BITS-1:0]   line_word_t;
    typedef logic [WIN_SIZE-1:0][PIX_BITS-1:0] win_t;

    // frame geometry and restart strobe from the register block
    typedef struct packed {
        wsize_t width;
        hsize_t height;
        logic   restart;
    } wmf_geom_t;

    // position of the window centre that travels with each result
    typedef struct packed {
        pos_field_t row;
        pos_field_t col;
    } wmf_pos_t;

endpackage

FILE: hdl/wmf_window.sv
// ----------------------------------------------------------------------------
// wmf_window
// Raster counters, four line stores in one memory and the 5x5 window.
// ----------------------------------------------------------------------------
module wmf_window
    import wmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  wmf_geom_t geom,
    input  logic      in_valid,
    output logic      in_ready,
    input  pix_t      pixel,
    output logic      out_valid,
    input  logic      out_ready,
    output win_t      win,
    output wmf_pos_t  pos
);

    col_t       col_count_reg, col_count_next;
    row_t       row_count_reg, row_count_next;
    col_t       c_eff;
    row_t       r_eff;
    wsize_t     c_inc;
    hsize_t     r_inc;
    logic       accept;
    logic       emit;

    logic       v1_reg;
    pix_t       p1_pixel_reg;
    col_t       p1_col_reg;
    logic       p1_emit_reg;
    wmf_pos_t   p1_pos_reg;
    line_word_t rd_reg;
    line_word_t wr_word;
    logic       en2;
    logic       adv1;

    logic       v2_reg;
    win_t       win_reg;
    wmf_pos_t   pos_reg;

    line_word_t mem [MAX_WIDTH];

    assign accept = in_valid && in_ready;

    always_comb
    begin
        c_eff = ({1'b0, col_count_reg} >= geom.width) ? '0 : col_count_reg;
        r_eff = ({1'b0, row_count_reg} >= geom.height) ? '0 : row_count_reg;
        c_inc = {1'b0, c_eff} + wsize_t'(1);
        r_inc = {1'b0, r_eff} + hsize_t'(1);
        emit  = (r_eff >= row_t'(4)) && (c_eff >= col_t'(4));

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        priority if (geom.restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (c_inc >= geom.width)
            begin
                col_count_next = '0;
                row_count_next = (r_inc >= geom.height) ? '0 : r_inc[ROW_BITS-1:0];
            end
            else
            begin
                col_count_next = c_inc[COL_BITS-1:0];
                row_count_next = r_eff;
            end
        end
        else
        begin
            col_count_next = col_count_reg;
            row_count_next = row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // stage 1: line store read in flight
    assign en2      = !v2_reg || out_ready;
    assign adv1     = v1_reg && en2;
    assign in_ready = !v1_reg || en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pixel_reg   <= pixel;
            p1_col_reg     <= c_eff;
            p1_emit_reg    <= emit;
            p1_pos_reg.row <= POS_BITS'(r_eff - row_t'(2));
            p1_pos_reg.col <= POS_BITS'(c_eff - col_t'(2));
        end
    end

    // column moves up one line; new pixel goes into the newest line
    always_comb
    begin
        for (int k = 0; k < LINES - 1; k++)
        begin
            wr_word[k] = rd_reg[k + 1];
        end
        wr_word[LINES-1] = p1_pixel_reg;
    end

    // consecutive pixels never share a column, so read and write never collide
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[c_eff];
        end
        if (adv1)
        begin
            mem[p1_col_reg] <= wr_word;
        end
    end

    // stage 2: window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= adv1 && p1_emit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (adv1)
        begin
            for (int k = 0; k < WIN_DIM; k++)
            begin
                for (int j = 0; j < WIN_DIM - 1; j++)
                begin
                    win_reg[k*WIN_DIM + j] <= win_reg[k*WIN_DIM + j + 1];
                end
                win_reg[k*WIN_DIM + WIN_DIM - 1] <=
                    (k == WIN_DIM - 1) ? p1_pixel_reg : rd_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            pos_reg <= p1_pos_reg;
        end
    end

    assign out_valid = v2_reg;
    assign win       = win_reg;
    assign pos       = pos_reg;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_count_reg} < geom.width)
        else $error("column counter beyond row width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_count_reg} < geom.height)
        else $error("row counter beyond frame height");

    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos.row >= pos_field_t'(2)) && (pos.col >= pos_field_t'(2)))
        else $error("result centre lies on the border");

endmodule

FILE: hdl/wmf_rank.sv
// ----------------------------------------------------------------------------
// wmf_rank
// Weighted rank of each window value and selection of the median.
// ----------------------------------------------------------------------------
module wmf_rank
    import wmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  win_t     win,
    input  wmf_pos_t pos,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_t     median,
    output wmf_pos_t out_pos
);

    logic [WIN_SIZE-1:0] qual_next;
    logic [WIN_SIZE-1:0] le_vec;
    logic [SUM_BITS-1:0] wsum;

    logic                va_reg;
    logic [WIN_SIZE-1:0] qual_reg;
    win_t                vals_reg;
    wmf_pos_t            pa_pos_reg;
    logic                en_a;
    logic                en_b;

    logic [WIN_SIZE-1:0] sel;
    logic [WIN_SIZE-1:0] lt_vec;
    pix_t                median_next;

    logic                vo_reg;
    pix_t                median_reg;
    wmf_pos_t            pos_reg;

    assign en_b     = !vo_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // weight of all values not above win[i]; qualifies at half the total
    always_comb
    begin
        le_vec = '0;
        wsum   = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                le_vec[j] = (win[j] <= win[i]);
            end
            wsum = SUM_BITS'($countones(le_vec & OUTER_MASK))
                 + SUM_BITS'(2 * $countones(le_vec & INNER_MASK));
            qual_next[i] = (wsum >= SUM_BITS'(HALF_WEIGHT));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en_a)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            qual_reg   <= qual_next;
            vals_reg   <= win;
            pa_pos_reg <= pos;
        end
    end

    // every qualifying value with no smaller qualifying value is the median;
    // they are all equal, so OR-ing them gives the value
    always_comb
    begin
        lt_vec      = '0;
        median_next = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                lt_vec[j] = (vals_reg[j] < vals_reg[i]);
            end
            sel[i] = qual_reg[i] && !(|(qual_reg & lt_vec));
            median_next = median_next | (sel[i] ? vals_reg[i] : pix_t'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en_b)
        begin
            vo_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && va_reg)
        begin
            median_reg <= median_next;
            pos_reg    <= pa_pos_reg;
        end
    end

    assign out_valid = vo_reg;
    assign median    = median_reg;
    assign out_pos   = pos_reg;

    a_some_qualifies: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> (|qual_reg))
        else $error("no window value reaches half the weight");

    a_median_selected: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> $countones(sel) >= 1)
        else $error("median select found no candidate");

endmodule

FILE: hdl/weighted_median_5x5_filter.sv
// ----------------------------------------------------------------------------
// weighted_median_5x5_filter
// 5x5 weighted median over a raster pixel stream, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one 8-bit pixel per transaction in raster order.
//   m_* channel gives one transaction per pixel once four rows and four
//   columns of the frame are in: the weighted median (inner 3x3 weight 2,
//   outer ring weight 1) of the window centred two rows up and two columns
//   left, with that centre's row and column. Border pixels give nothing.
//   cfg_we/cfg_index/cfg_wdata set image_width (index 0) and image_height
//   (index 1); sizes clamp to 5..1024. A write restarts the frame at row 0,
//   column 0. Write only while no transaction is in flight.
// Pipeline: a result reaches m_tvalid through the line store read, window
//   shift, rank and select stages, each registered.
// Throughput: one pixel per clock sustained while the result side does not stall;
//   set by the single-port-per-direction line store, read at the current
//   column and written when that pixel leaves stage 1.
// Reset: sizes return to 512, counters to zero, pipeline empties. The line
//   store is not cleared; stale entries leave the window before any result.
// Stall: while m_tready is low the output register holds; the pipeline
//   keeps taking pixels until its four stages fill, then s_tready drops.
// ----------------------------------------------------------------------------
module weighted_median_5x5_filter
    import wmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // pixel stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] pixel
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [7:0] median, [17:8] center_row,
                                           // [27:18] center_col, [31:28] zero
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    logic [CFG_BITS-1:0] image_width_reg;
    logic [CFG_BITS-1:0] image_height_reg;
    wmf_geom_t           geom;

    logic                win_valid;
    logic                win_ready;
    win_t                win;
    wmf_pos_t            win_pos;
    pix_t                median;
    wmf_pos_t            res_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_BITS'(512);
            image_height_reg <= CFG_BITS'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // clamp the programmed sizes into the supported range
    always_comb
    begin
        if (int'(image_width_reg) < MIN_SIZE)
            geom.width = wsize_t'(MIN_SIZE);
        else if (int'(image_width_reg) > MAX_WIDTH)
            geom.width = wsize_t'(MAX_WIDTH);
        else
            geom.width = wsize_t'(image_width_reg);

        if (int'(image_height_reg) < MIN_SIZE)
            geom.height = hsize_t'(MIN_SIZE);
        else if (int'(image_height_reg) > MAX_HEIGHT)
            geom.height = hsize_t'(MAX_HEIGHT);
        else
            geom.height = hsize_t'(image_height_reg);

        // any register write starts a new frame
        geom.restart = cfg_we;
    end

    wmf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel     (s_tdata),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .win       (win),
        .pos       (win_pos)
    );

    wmf_rank u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .win       (win),
        .pos       (win_pos),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .median    (median),
        .out_pos   (res_pos)
    );

    assign m_tdata = {4'b0000, res_pos.col, res_pos.row, median};

endmodule

FILE: bench/tb_weighted_median_5x5_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_median_5x5_filter
// Self-checking bench for the 5x5 weighted median filter.
// ----------------------------------------------------------------------------
// A short directed table covers clamped sizes, black and white extremes and
// one frame whose median is obvious. Random frames of many small sizes follow,
// then a final phase with no idling.
// Every result is checked against a bit-true predictor of the line stores,
// the window and the raster counters in this bench, or a typed table entry.
// ----------------------------------------------------------------------------
module tb_weighted_median_5x5_filter;
    import wmf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 8;     // pipeline is four deep, keep margin
    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int LONG_HOLD     = 64;    // long result back-pressure
    localparam int RANDOM_PIXELS = 1350;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;
    typedef enum logic [1:0] {FILL_UNIFORM, FILL_CLUSTER, FILL_EXTREME, FILL_RAMP} fill_mode_t;

    // one result: median and window centre position
    typedef struct packed {
        pos_field_t col;
        pos_field_t row;
        pix_t       med;
    } median_result_t;

    // one directed row; idx only matters for STEP_CFG, val is the pixel otherwise
    typedef struct packed {
        step_kind_t          kind;
        logic                idx;
        logic [CFG_BITS-1:0] val;
        logic                typed;
        median_result_t      want;
    } step_t;

    localparam median_result_t NO_RESULT = '0;

    // ------------------------------------------------------------------------
    // DUT ports, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    weighted_median_5x5_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of registers, line stores and window
    // ------------------------------------------------------------------------
    logic [CFG_BITS-1:0] width_reg  = 11'd512;
    logic [CFG_BITS-1:0] height_reg = 11'd512;
    pix_t                line_mem [LINES][MAX_WIDTH];   // [0] is the oldest row
    pix_t                win_px   [WIN_SIZE];           // row-major, right column newest
    int                  row_pos = 0;
    int                  col_pos = 0;

    median_result_t      median_q [$];                  // medians still due
    int                  error_count = 0;
    bit                  idle_en = 1'b0;                // random bursts on both sides
    bit                  long_hold_req = 1'b0;          // ask the receiver for a long hold
    int                  quiet_cycles = 0;

    // Sizes below five act as five, above the maximum as the maximum.
    function automatic int clamp_dim(input logic [CFG_BITS-1:0] v, input int top);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    // Smallest window value whose weight of values not above it reaches half.
    function automatic pix_t window_median();
        pix_t best;
        int   acc;
        best = 8'hFF;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            acc = 0;
            for (int j = 0; j < WIN_SIZE; j++)
                if (win_px[j] <= win_px[i])
                    acc += INNER_MASK[j] ? 2 : 1;
            if (acc >= HALF_WEIGHT && win_px[i] < best)
                best = win_px[i];
        end
        return best;
    endfunction

    // Advance the predictor by one pixel; returns 1 when a median is due.
    function automatic bit filter_pixel(input pix_t p, output median_result_t res);
        int   w;
        int   h;
        int   c;
        int   r;
        bit   hit;
        pix_t column [WIN_DIM];
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        c   = (col_pos >= w) ? 0 : col_pos;
        r   = (row_pos >= h) ? 0 : row_pos;
        hit = 1'b0;
        res = NO_RESULT;

        // new right-hand column: stored rows on top, new pixel at the bottom
        for (int k = 0; k < LINES; k++)
            column[k] = line_mem[k][c];
        column[WIN_DIM-1] = p;
        for (int k = 0; k < LINES; k++)
            line_mem[k][c] = column[k+1];

        for (int k = 0; k < WIN_DIM; k++)
        begin
            for (int j = 0; j < WIN_DIM - 1; j++)
                win_px[k*WIN_DIM + j] = win_px[k*WIN_DIM + j + 1];
            win_px[k*WIN_DIM + WIN_DIM - 1] = column[k];
        end

        // border rows and columns give nothing
        if (r >= 4 && c >= 4)
        begin
            res.med = window_median();
            res.row = pos_field_t'(r - 2);
            res.col = pos_field_t'(c - 2);
            hit     = 1'b1;
        end

        // raster advance, wrapping after the last pixel of the frame
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: sizes that clamp, then one 5x5 frame with a black ring
    // around a white 3x3. The ring weighs 16 < 17, so the median is white.
    // ------------------------------------------------------------------------
    step_t dir_steps [27] = '{
        '{STEP_CFG,   CFG_IMAGE_WIDTH,  11'd3,   1'b0, NO_RESULT},  // acts as 5
        '{STEP_CFG,   CFG_IMAGE_HEIGHT, 11'd0,   1'b0, NO_RESULT},  // acts as 5
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b0, NO_RESULT},
        // last pixel of the frame: only result, centre at row 2 column 2
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,   1'b1,
          '{col: 10'd2, row: 10'd2, med: 8'd255}}
    };

    // ------------------------------------------------------------------------
    // Stimulus helpers; every task that drives the DUT starts and ends just after a falling edge
    // ------------------------------------------------------------------------
    function automatic pix_t make_pixel(input fill_mode_t mode, input int n, input pix_t base);
        // a little noise in every structured fill
        if (mode != FILL_UNIFORM && $urandom_range(0, 7) == 0)
            return pix_t'($urandom());
        case (mode)
            FILL_CLUSTER: return base + pix_t'($urandom_range(0, 3));   // many ties
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_RAMP:    return pix_t'(n * 3 + $urandom_range(0, 7));
            default:      return pix_t'($urandom());
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Offer one pixel until the transaction completes, then update the predictor.
    task automatic send_pixel(input pix_t p, input bit typed, input median_result_t typed_res);
        median_result_t res;
        bit             hit;
        int             gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hit = filter_pixel(p, res);
        if (typed)
            median_q.push_back(typed_res);
        else if (hit)
            median_q.push_back(res);
        @(negedge clk);
    endtask

    // Stop offering, wait for every due median, then let the pipeline empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (median_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write; also restarts the frame in the predictor.
    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        row_pos = 0;
        col_pos = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure bursts plus one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                // counted here so the sender keeps going and the pipe backs up
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                m_tready  <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every result transaction is compared against the oldest due median.
    always @(posedge clk)
    begin
        median_result_t want;
        median_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.med = m_tdata[7:0];
            got.row = m_tdata[17:8];
            got.col = m_tdata[27:18];
            if (median_q.size() == 0)
                flag_error($sformatf("unexpected result median %0d row %0d col %0d",
                                     got.med, got.row, got.col));
            else
            begin
                want = median_q.pop_front();
                if (got.med !== want.med || got.row !== want.row || got.col !== want.col)
                    flag_error($sformatf({"expected median %0d row %0d col %0d, ",
                                          "got median %0d row %0d col %0d"},
                                         want.med, want.row, want.col,
                                         got.med, got.row, got.col));
            end
        end
    end

    // Watchdog: any transaction or register write resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                  phase;
        int                  n_px;
        int                  w_eff;
        int                  h_eff;
        int                  random_pixels;
        logic [CFG_BITS-1:0] wv;
        logic [CFG_BITS-1:0] hv;
        fill_mode_t          fill;
        pix_t                base;

        for (int k = 0; k < LINES; k++)
            for (int j = 0; j < MAX_WIDTH; j++)
                line_mem[k][j] = '0;
        foreach (win_px[i])
            win_px[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, with idling on
        idle_en = 1'b1;
        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_CFG)
            begin
                if (i == 0 || dir_steps[i-1].kind == STEP_PIXEL)
                    wait_idle();
                write_reg(dir_steps[i].idx, dir_steps[i].val);
            end
            else
                send_pixel(pix_t'(dir_steps[i].val), dir_steps[i].typed, dir_steps[i].want);
        end

        // random frames of small sizes; frames are often cut short by a write
        phase         = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            wait_idle();
            idle_en = ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 2)
            begin
                // fixed 8x8 so results are flowing when the pressure hits
                write_reg(CFG_IMAGE_WIDTH, 11'd8);
                write_reg(CFG_IMAGE_HEIGHT, 11'd8);
                idle_en = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       wv = CFG_BITS'($urandom_range(0, 4));
                    1, 2:    wv = CFG_BITS'($urandom_range(13, 40));
                    default: wv = CFG_BITS'($urandom_range(5, 12));
                endcase
                case ($urandom_range(0, 7))
                    0:       hv = CFG_BITS'($urandom_range(0, 4));
                    1:       hv = CFG_BITS'($urandom_range(0, 2047));
                    default: hv = CFG_BITS'($urandom_range(5, 9));
                endcase
                case ($urandom_range(0, 3))
                    0:
                    begin
                        write_reg(CFG_IMAGE_WIDTH, wv);
                        write_reg(CFG_IMAGE_HEIGHT, hv);
                    end
                    1:
                    begin
                        write_reg(CFG_IMAGE_HEIGHT, hv);
                        write_reg(CFG_IMAGE_WIDTH, wv);
                    end
                    2:       write_reg(CFG_IMAGE_WIDTH, wv);
                    default: write_reg(CFG_IMAGE_HEIGHT, hv);
                endcase
            end

            w_eff = clamp_dim(width_reg, MAX_WIDTH);
            h_eff = clamp_dim(height_reg, MAX_HEIGHT);
            if (phase == 1 || phase == 2)
                n_px = 200;
            else if (h_eff <= 12)
                n_px = w_eff * h_eff * $urandom_range(1, 2)
                     + $urandom_range(0, w_eff * h_eff - 1);
            else
                n_px = w_eff * $urandom_range(5, 12) + $urandom_range(0, w_eff - 1);
            if (n_px > 600)
                n_px = 600;
            if (n_px > RANDOM_PIXELS - random_pixels)
                n_px = RANDOM_PIXELS - random_pixels;

            fill = fill_mode_t'($urandom_range(0, 3));
            base = pix_t'($urandom());
            for (int k = 0; k < n_px; k++)
            begin
                // pixel 100 of an 8x8 run sits at row 4 of the second frame
                if (k == 100 && phase == 1)
                    long_hold_req = 1'b1;
                if (k == 100 && phase == 2)
                    wait_idle();
                send_pixel(make_pixel(fill, k, base), 1'b0, NO_RESULT);
            end
            random_pixels += n_px;
            phase++;
        end

        // closing phase with no idling on either side
        wait_idle();
        idle_en = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, 11'($urandom_range(5, 12)));
        write_reg(CFG_IMAGE_HEIGHT, 11'($urandom_range(5, 9)));
        n_px = clamp_dim(width_reg, MAX_WIDTH) * (clamp_dim(height_reg, MAX_HEIGHT) + 1);
        base = pix_t'($urandom());
        for (int k = 0; k < n_px; k++)
            send_pixel(make_pixel(fill_mode_t'($urandom_range(0, 3)), k, base), 1'b0, NO_RESULT);

        // drain: the watchdog bounds this wait
        s_tvalid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (median_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", median_q.size()));

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
